// ===== rtl/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Types and constants shared by the MIDI receive parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam logic [7:0] SYSTEM_STATUS = 8'hF0;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ADDR_BYTES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LISTEN_ALL  = 3'd0,
    REG_MY_CHANNEL  = 3'd1,
    REG_SYSEX_ADDR0 = 3'd2,
    REG_SYSEX_ADDR1 = 3'd3,
    REG_SYSEX_ADDR2 = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    KIND_PAIR  = 1'b0,
    KIND_SYSEX = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    PHASE_NONE   = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    logic                             listen_all;
    logic [3:0]                       my_channel;
    logic [ADDR_BYTES-1:0][6:0]       sysex_addr;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] status;
    logic [3:0] chan;
    logic [6:0] data1;
    logic [6:0] data2;
  } msg_t;

endpackage

// ===== rtl/mrp_if.sv =====
// ----------------------------------------------------------------------------
// mrp interfaces
// Valid/ready channels for received bytes, parsed messages and register writes.
// ----------------------------------------------------------------------------
interface mrp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrp_msg_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] status;
  logic [3:0] chan;
  logic [6:0] data1;
  logic [6:0] data2;

  modport source (output valid, output kind, output status, output chan,
                  output data1, output data2, input ready);
  modport sink (input valid, input kind, input status, input chan,
                input data1, input data2, output ready);
endinterface

interface mrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/midi_receive_parser.sv =====
// ----------------------------------------------------------------------------
// midi_receive_parser
// MIDI receive parser with running status, channel filter and addressed sysex.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock. A byte is registered on acceptance
// and runs through the parser state update once the output register is free.
// Its message, if any, is written to the output register at the end of that
// step, so a message passes the input register and then the output register
// before it is offered. The parser state update sets the rate of one byte per
// cycle. The input stalls only while a byte waits behind a message held at the
// output. Register writes are registered in cfg_q and are always accepted.
module midi_receive_parser
  import mrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mrp_rx_if.sink    rx_i,
  mrp_cfg_if.sink   cfg_i,
  mrp_msg_if.source msg_o
);

  cfg_t       cfg_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  msg_t       out_q;
  logic       out_free;
  logic       step;
  logic       rslt_vld;
  msg_t       rslt;

  assign out_free   = !out_vld_q || msg_o.ready;
  assign step       = in_vld_q && out_free;
  assign rx_i.ready = !in_vld_q || out_free;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LISTEN_ALL:  cfg_q.listen_all    <= cfg_i.data[0];
        REG_MY_CHANNEL:  cfg_q.my_channel    <= cfg_i.data[3:0];
        REG_SYSEX_ADDR0: cfg_q.sysex_addr[0] <= cfg_i.data[6:0];
        REG_SYSEX_ADDR1: cfg_q.sysex_addr[1] <= cfg_i.data[6:0];
        REG_SYSEX_ADDR2: cfg_q.sysex_addr[2] <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  mrp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg_q),
    .rslt_vld_o (rslt_vld),
    .rslt_o     (rslt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= rslt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rslt_vld) begin
      out_q <= rslt;
    end
  end

  assign msg_o.valid  = out_vld_q;
  assign msg_o.kind   = out_q.kind;
  assign msg_o.status = out_q.status;
  assign msg_o.chan   = out_q.chan;
  assign msg_o.data1  = out_q.data1;
  assign msg_o.data2  = out_q.data2;

`ifndef ASSERT_OFF
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !msg_o.ready) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled message changed");

  a_no_step_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !msg_o.ready) |-> !step)
    else $error("parser stepped into a full output register");

  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("pending byte lost");
`endif

endmodule

// ===== rtl/mrp_parser.sv =====
// ----------------------------------------------------------------------------
// mrp_parser
// Running-status and addressed sysex state, updated once per stepped byte.
// ----------------------------------------------------------------------------
module mrp_parser
  import mrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       rslt_vld_o,
  output msg_t       rslt_o
);

  logic       routing_q, routing_d;
  logic       in_sysex_q, in_sysex_d;
  logic       match_q, match_d;
  logic [1:0] count_q, count_d;
  phase_e     phase_q, phase_d;
  logic [7:0] last_status_q, last_status_d;
  logic [3:0] last_chan_q, last_chan_d;
  logic [6:0] held_q, held_d;

  logic       accept;
  logic [6:0] expected;

  always_comb begin
    case (count_q)
      2'd0:    expected = cfg_i.sysex_addr[0];
      2'd1:    expected = cfg_i.sysex_addr[1];
      2'd2:    expected = cfg_i.sysex_addr[2];
      default: expected = '0;
    endcase
  end

  assign accept = cfg_i.listen_all || (byte_i[7:4] == SYSTEM_STATUS[7:4]) ||
                  (byte_i[3:0] == cfg_i.my_channel);

  always_comb begin
    routing_d     = routing_q;
    in_sysex_d    = in_sysex_q;
    match_d       = match_q;
    count_d       = count_q;
    phase_d       = phase_q;
    last_status_d = last_status_q;
    last_chan_d   = last_chan_q;
    held_d        = held_q;
    rslt_vld_o    = 1'b0;
    rslt_o.kind   = KIND_PAIR;
    rslt_o.status = last_status_q;
    rslt_o.chan   = last_chan_q;
    rslt_o.data1  = held_q;
    rslt_o.data2  = byte_i[6:0];
    if (step_i) begin
      if (byte_i[7]) begin
        if (!accept) begin
          routing_d = 1'b0;
        end else begin
          routing_d     = 1'b1;
          last_status_d = (byte_i[7:4] != SYSTEM_STATUS[7:4]) ? {byte_i[7:4], 4'h0} : byte_i;
          last_chan_d   = byte_i[3:0];
          phase_d       = PHASE_FIRST;
          if (byte_i == SYSTEM_STATUS) begin
            count_d    = 2'd0;
            in_sysex_d = 1'b1;
            match_d    = 1'b1;
          end else begin
            in_sysex_d = 1'b0;
          end
        end
      end else if (routing_q) begin
        if (in_sysex_q) begin
          if (count_q != 2'd3) begin
            if (byte_i[6:0] != expected) begin
              match_d = 1'b0;
            end
            count_d = count_q + 2'd1;
          end else if (match_q) begin
            rslt_vld_o   = 1'b1;
            rslt_o.kind  = KIND_SYSEX;
            rslt_o.data1 = byte_i[6:0];
            rslt_o.data2 = '0;
          end
        end else begin
          case (phase_q)
            PHASE_FIRST: begin
              held_d  = byte_i[6:0];
              phase_d = PHASE_SECOND;
            end
            PHASE_SECOND: begin
              rslt_vld_o = 1'b1;
              phase_d    = PHASE_FIRST;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      routing_q     <= 1'b0;
      in_sysex_q    <= 1'b0;
      match_q       <= 1'b0;
      count_q       <= 2'd0;
      phase_q       <= PHASE_NONE;
      last_status_q <= '0;
      last_chan_q   <= '0;
      held_q        <= '0;
    end else begin
      routing_q     <= routing_d;
      in_sysex_q    <= in_sysex_d;
      match_q       <= match_d;
      count_q       <= count_d;
      phase_q       <= phase_d;
      last_status_q <= last_status_d;
      last_chan_q   <= last_chan_d;
      held_q        <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_result_unrouted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !routing_q |-> !rslt_vld_o)
    else $error("result while data is ignored");

  a_sysex_after_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rslt_vld_o && rslt_o.kind == KIND_SYSEX) |-> (in_sysex_q && match_q && count_q == 2'd3))
    else $error("sysex payload before address matched");

  a_pair_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rslt_vld_o && rslt_o.kind == KIND_PAIR) |=> (phase_q == PHASE_FIRST))
    else $error("pair did not restart the data phase");

  a_status_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && byte_i[7] && accept) |=> (routing_q && phase_q == PHASE_FIRST))
    else $error("accepted status did not restart parsing");
`endif

endmodule
